// File: rtl/core/scsort_pkg.sv
// ----------------------------------------------------------------------------
// scsort_pkg
// Shared types, sizes and helpers for the stable counting sort block.
// ----------------------------------------------------------------------------
package scsort_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int KEY_VALUES  = 128;
  localparam int KEY_W       = 7;
  localparam int WORD_W      = 16;

  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int BKT_W  = $clog2(KEY_VALUES);
  localparam int KCNT_W = $clog2(KEY_VALUES + 1);
  localparam int ST_AW  = $clog2(2 * MAX_RECORDS);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
  } rec_t;

  // keys beyond the key range fall into the top bucket
  function automatic logic [BKT_W-1:0] bucket_of(logic [KEY_W-1:0] key);
    logic [BKT_W-1:0] b;
    if (int'(key) >= KEY_VALUES) begin
      b = BKT_W'(KEY_VALUES - 1);
    end else begin
      b = BKT_W'(key);
    end
    return b;
  endfunction

endpackage

// File: rtl/core/stable_counting_sort_by_priority.sv
// ----------------------------------------------------------------------------
// stable_counting_sort_by_priority
// Stable counting sort of sprite records by 7-bit priority key, built around
// a key histogram RAM and a record RAM holding load and sorted halves.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------
//  input    | start_i, busy_o              | sort_key_i, attr_word0..2_i,
//           |                              | batch_end_i
//  result   | result_strobe_o (no stall)   | out_key_o, out_word0..2_o,
//           |                              | out_last_o, overflowed_o
//
// Records load back to back while busy_o stays low. After the record with
// batch_end_i come a flush state, a prefix pass over the histogram RAM, a
// scatter of the n records into the sorted half of the record RAM, then
// the emit state, which outputs one result per cycle.
// Reset clears control state and the histogram valid bits; no RAM sweep.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module stable_counting_sort_by_priority
  import scsort_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [KEY_W-1:0]  sort_key_i,
  input  logic [WORD_W-1:0] attr_word0_i,
  input  logic [WORD_W-1:0] attr_word1_i,
  input  logic [WORD_W-1:0] attr_word2_i,
  input  logic              batch_end_i,
  output logic              result_strobe_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [WORD_W-1:0] out_word0_o,
  output logic [WORD_W-1:0] out_word1_o,
  output logic [WORD_W-1:0] out_word2_o,
  output logic              out_last_o,
  output logic              overflowed_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FLUSH   = 3'd1;
  localparam logic [2:0] S_PFX     = 3'd2;
  localparam logic [2:0] S_SCAT_RD = 3'd3;
  localparam logic [2:0] S_SCAT_HR = 3'd4;
  localparam logic [2:0] S_SCAT_WR = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  // memories
  logic [CNT_W-1:0] h_mem [KEY_VALUES];
  rec_t             st_mem [2*MAX_RECORDS];

  logic             h_re, h_we;
  logic [BKT_W-1:0] h_raddr, h_waddr;
  logic [CNT_W-1:0] h_wdata, h_rdata_q;

  logic             st_re, st_we;
  logic [ST_AW-1:0] st_raddr, st_waddr;
  rec_t             st_wdata, st_rdata_q;

  always_ff @(posedge clk_i) begin
    if (h_re) begin
      h_rdata_q <= h_mem[h_raddr];
    end
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_re) begin
      st_rdata_q <= st_mem[st_raddr];
    end
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
  end

  // control state
  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic [KEY_VALUES-1:0] hv_q, hv_d;
  logic                  inc_v_q, inc_v_d;
  logic [BKT_W-1:0]      inc_b_q, inc_b_d;
  logic                  fwd_v_q, fwd_v_d;
  logic [BKT_W-1:0]      fwd_b_q, fwd_b_d;
  logic [CNT_W-1:0]      fwd_val_q, fwd_val_d;
  logic [KCNT_W-1:0]     rk_q, rk_d;
  logic                  pfx_v_q, pfx_v_d;
  logic [BKT_W-1:0]      pfx_k_q, pfx_k_d;
  logic [CNT_W-1:0]      run_q, run_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  rec_t                  rec_q, rec_d;
  logic [BKT_W-1:0]      sc_b_q, sc_b_d;
  logic                  ostb_q, ostb_d;
  logic                  olast_q, olast_d;
  logic                  oovf_q, oovf_d;

  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] pfx_cnt;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] idx_inc;
  rec_t             in_rec;

  assign in_rec  = '{key: sort_key_i, w0: attr_word0_i, w1: attr_word1_i,
                     w2: attr_word2_i};
  assign idx_inc = idx_q + CNT_W'(1);

  always_comb begin
    if (fwd_v_q && (fwd_b_q == inc_b_q)) begin
      cur_cnt = fwd_val_q;
    end else if (hv_q[inc_b_q]) begin
      cur_cnt = h_rdata_q;
    end else begin
      cur_cnt = '0;
    end
    pfx_cnt = hv_q[pfx_k_q] ? h_rdata_q : '0;
    pos = (h_rdata_q >= cnt_q) ? (cnt_q - CNT_W'(1)) : h_rdata_q;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    hv_d      = hv_q;
    inc_v_d   = 1'b0;
    inc_b_d   = inc_b_q;
    fwd_v_d   = 1'b0;
    fwd_b_d   = fwd_b_q;
    fwd_val_d = fwd_val_q;
    rk_d      = rk_q;
    pfx_v_d   = 1'b0;
    pfx_k_d   = pfx_k_q;
    run_d     = run_q;
    idx_d     = idx_q;
    rec_d     = rec_q;
    sc_b_d    = sc_b_q;
    ostb_d    = 1'b0;
    olast_d   = olast_q;
    oovf_d    = oovf_q;

    h_re     = 1'b0;
    h_raddr  = '0;
    h_we     = 1'b0;
    h_waddr  = '0;
    h_wdata  = '0;
    st_re    = 1'b0;
    st_raddr = '0;
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = rec_q;

    // histogram increment of the previous transaction, with forwarding
    if (inc_v_q) begin
      h_we            = 1'b1;
      h_waddr         = inc_b_q;
      h_wdata         = cur_cnt + CNT_W'(1);
      hv_d[inc_b_q]   = 1'b1;
      fwd_v_d         = 1'b1;
      fwd_b_d         = inc_b_q;
      fwd_val_d       = cur_cnt + CNT_W'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (cnt_q < CNT_W'(MAX_RECORDS)) begin
            st_we    = 1'b1;
            st_waddr = ST_AW'(cnt_q);
            st_wdata = in_rec;
            h_re     = 1'b1;
            h_raddr  = bucket_of(sort_key_i);
            inc_v_d  = 1'b1;
            inc_b_d  = bucket_of(sort_key_i);
            cnt_d    = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (batch_end_i) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        rk_d    = '0;
        run_d   = '0;
        state_d = S_PFX;
      end
      S_PFX: begin
        if (pfx_v_q) begin
          h_we          = 1'b1;
          h_waddr       = pfx_k_q;
          h_wdata       = run_q;
          hv_d[pfx_k_q] = 1'b1;
          run_d         = run_q + pfx_cnt;
        end
        if (rk_q < KCNT_W'(KEY_VALUES)) begin
          h_re    = 1'b1;
          h_raddr = rk_q[BKT_W-1:0];
          pfx_v_d = 1'b1;
          pfx_k_d = rk_q[BKT_W-1:0];
          rk_d    = rk_q + KCNT_W'(1);
        end else begin
          idx_d   = '0;
          state_d = S_SCAT_RD;
        end
      end
      S_SCAT_RD: begin
        st_re    = 1'b1;
        st_raddr = ST_AW'(idx_q);
        state_d  = S_SCAT_HR;
      end
      S_SCAT_HR: begin
        rec_d   = st_rdata_q;
        sc_b_d  = bucket_of(st_rdata_q.key);
        h_re    = 1'b1;
        h_raddr = bucket_of(st_rdata_q.key);
        state_d = S_SCAT_WR;
      end
      S_SCAT_WR: begin
        st_we    = 1'b1;
        st_waddr = ST_AW'(pos) + ST_AW'(MAX_RECORDS);
        st_wdata = rec_q;
        h_we     = 1'b1;
        h_waddr  = sc_b_q;
        h_wdata  = h_rdata_q + CNT_W'(1);
        if (idx_inc == cnt_q) begin
          idx_d   = '0;
          state_d = S_EMIT;
        end else begin
          idx_d    = idx_inc;
          st_re    = 1'b1;
          st_raddr = ST_AW'(idx_inc);
          state_d  = S_SCAT_HR;
        end
      end
      S_EMIT: begin
        st_re    = 1'b1;
        st_raddr = ST_AW'(idx_q) + ST_AW'(MAX_RECORDS);
        ostb_d   = 1'b1;
        olast_d  = (idx_inc == cnt_q);
        oovf_d   = ovf_q;
        idx_d    = idx_inc;
        if (idx_inc == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          hv_d    = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      hv_q    <= '0;
      inc_v_q <= 1'b0;
      fwd_v_q <= 1'b0;
      pfx_v_q <= 1'b0;
      rk_q    <= '0;
      idx_q   <= '0;
      run_q   <= '0;
      ostb_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      hv_q    <= hv_d;
      inc_v_q <= inc_v_d;
      fwd_v_q <= fwd_v_d;
      pfx_v_q <= pfx_v_d;
      rk_q    <= rk_d;
      idx_q   <= idx_d;
      run_q   <= run_d;
      ostb_q  <= ostb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inc_b_q   <= inc_b_d;
    fwd_b_q   <= fwd_b_d;
    fwd_val_q <= fwd_val_d;
    pfx_k_q   <= pfx_k_d;
    rec_q     <= rec_d;
    sc_b_q    <= sc_b_d;
    olast_q   <= olast_d;
    oovf_q    <= oovf_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_strobe_o = ostb_q;
  assign out_key_o       = st_rdata_q.key;
  assign out_word0_o     = st_rdata_q.w0;
  assign out_word1_o     = st_rdata_q.w1;
  assign out_word2_o     = st_rdata_q.w2;
  assign out_last_o      = olast_q;
  assign overflowed_o    = oovf_q;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stable counting sort. A queue of sprite records
// feeds a start/busy driver, a local model sorts each batch stably by key, and
// a monitor compares every strobed result against the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
  import scsort_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_TAIL   = 30;
  localparam int DRAIN_WAIT  = 300;
  localparam int TOTAL_ITEMS = 220;

  typedef struct {
    rec_t rec;
    bit   fin;
  } sprite_in_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic              last;
    logic              ovf;
  } sorted_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [KEY_W-1:0]  sort_key_i = '0;
  logic [WORD_W-1:0] attr_word0_i = '0;
  logic [WORD_W-1:0] attr_word1_i = '0;
  logic [WORD_W-1:0] attr_word2_i = '0;
  logic              batch_end_i = 1'b0;
  logic              result_strobe_o;
  logic [KEY_W-1:0]  out_key_o;
  logic [WORD_W-1:0] out_word0_o;
  logic [WORD_W-1:0] out_word1_o;
  logic [WORD_W-1:0] out_word2_o;
  logic              out_last_o;
  logic              overflowed_o;

  stable_counting_sort_by_priority dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sort_key_i     (sort_key_i),
    .attr_word0_i   (attr_word0_i),
    .attr_word1_i   (attr_word1_i),
    .attr_word2_i   (attr_word2_i),
    .batch_end_i    (batch_end_i),
    .result_strobe_o(result_strobe_o),
    .out_key_o      (out_key_o),
    .out_word0_o    (out_word0_o),
    .out_word1_o    (out_word1_o),
    .out_word2_o    (out_word2_o),
    .out_last_o     (out_last_o),
    .overflowed_o   (overflowed_o)
  );

  sprite_in_t  record_feed[$];
  sorted_out_t sorted_due[$];

  // local copy of the sort state
  int unsigned key_tally[KEY_VALUES];
  rec_t        held_recs[MAX_RECORDS];
  int unsigned held_count;
  bit          dropped;

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned records_fed;
  int unsigned batches_done;
  int unsigned overflow_batches;
  int unsigned cycle_count;
  int unsigned gap_left;
  int unsigned gap_pct;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned key_bucket(logic [KEY_W-1:0] key);
    if (int'(key) >= KEY_VALUES) begin
      return KEY_VALUES - 1;
    end
    return int'(key);
  endfunction

  task automatic take_record(sprite_in_t item);
    int unsigned first_pos[KEY_VALUES];
    sorted_out_t placed[MAX_RECORDS];
    int unsigned run;
    int unsigned b;
    int unsigned pos;
    if (held_count < MAX_RECORDS) begin
      held_recs[held_count] = item.rec;
      key_tally[key_bucket(item.rec.key)]++;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (item.fin) begin
      run = 0;
      for (int i = 0; i < KEY_VALUES; i++) begin
        first_pos[i] = run;
        run += key_tally[i];
      end
      for (int i = 0; i < held_count; i++) begin
        b = key_bucket(held_recs[i].key);
        pos = first_pos[b];
        first_pos[b]++;
        placed[pos].key  = held_recs[i].key;
        placed[pos].w0   = held_recs[i].w0;
        placed[pos].w1   = held_recs[i].w1;
        placed[pos].w2   = held_recs[i].w2;
        placed[pos].last = (pos == held_count - 1);
        placed[pos].ovf  = dropped;
      end
      for (int i = 0; i < held_count; i++) begin
        sorted_due.push_back(placed[i]);
      end
      batches_done++;
      if (dropped) begin
        overflow_batches++;
      end
      foreach (key_tally[i]) key_tally[i] = 0;
      held_count = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_item(int unsigned key, int unsigned w0, int unsigned w1,
                          int unsigned w2, bit fin);
    sprite_in_t item;
    item.rec.key = KEY_W'(key);
    item.rec.w0  = WORD_W'(w0);
    item.rec.w1  = WORD_W'(w1);
    item.rec.w2  = WORD_W'(w2);
    item.fin     = fin;
    record_feed.push_back(item);
  endtask

  // narrow keys force plenty of ties, so ordering among equals gets exercised
  task automatic add_batch(int unsigned len);
    bit narrow;
    narrow = ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      add_item(narrow ? $urandom_range(3) : $urandom_range((1 << KEY_W) - 1),
               $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
               $urandom_range(16'hFFFF), i == len - 1);
    end
  endtask

  // driver
  always @(posedge clk_i) begin : drive_proc
    bit took;
    took = 1'b0;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        take_record(record_feed[0]);
        if (record_feed[0].fin) begin
          gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
        end
        void'(record_feed.pop_front());
        records_fed++;
        took = 1'b1;
      end
      if (!start_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
          sort_key_i <= KEY_W'($urandom);
          attr_word0_i <= WORD_W'($urandom);
          batch_end_i <= 1'($urandom);
        end else if (record_feed.size() > CALM_TAIL && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(8);
          start_i <= 1'b0;
          sort_key_i <= KEY_W'($urandom);
          attr_word0_i <= WORD_W'($urandom);
          batch_end_i <= 1'($urandom);
        end else if (record_feed.size() > 0) begin
          start_i <= 1'b1;
          sort_key_i <= record_feed[0].rec.key;
          attr_word0_i <= record_feed[0].rec.w0;
          attr_word1_i <= record_feed[0].rec.w1;
          attr_word2_i <= record_feed[0].rec.w2;
          batch_end_i <= record_feed[0].fin;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_proc
    sorted_out_t want;
    if (rst_ni && result_strobe_o) begin
      if (sorted_due.size() == 0) begin
        $display("[%0t] unexpected result, key 0x%0h", $time, out_key_o);
        mismatches++;
      end else begin
        want = sorted_due.pop_front();
        results_checked++;
        if (out_key_o !== want.key) report("out_key", out_key_o, want.key);
        if (out_word0_o !== want.w0) report("out_word0", out_word0_o, want.w0);
        if (out_word1_o !== want.w1) report("out_word1", out_word1_o, want.w1);
        if (out_word2_o !== want.w2) report("out_word2", out_word2_o, want.w2);
        if (out_last_o !== want.last) report("out_last", out_last_o, want.last);
        if (overflowed_o !== want.ovf) report("overflowed", overflowed_o, want.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sorted_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : main_proc
    int unsigned len;
    foreach (key_tally[i]) key_tally[i] = 0;
    held_count = 0;
    dropped = 1'b0;
    mismatches = 0;
    results_checked = 0;
    records_fed = 0;
    batches_done = 0;
    overflow_batches = 0;
    cycle_count = 0;
    gap_left = 0;
    gap_pct = 0;

    // directed: lone records at the key and word extremes
    add_item(0, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    add_item(127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // ties interleaved with other keys, plus both key extremes
    add_item(5, 16'h0001, 16'h5555, 16'hAAAA, 1'b0);
    add_item(3, 16'h0002, 16'hAAAA, 16'h5555, 1'b0);
    add_item(5, 16'h0003, 16'h1234, 16'h8000, 1'b0);
    add_item(3, 16'h0004, 16'hFEDC, 16'h0001, 1'b0);
    add_item(127, 16'h0005, 16'h0F0F, 16'hF0F0, 1'b0);
    add_item(0, 16'h0006, 16'hF0F0, 16'h0F0F, 1'b1);
    // all keys equal
    for (int i = 0; i < 4; i++) begin
      add_item(7, 16'h1000 + i, 16'h2000 + i, 16'h3000 + i, i == 3);
    end
    // strictly descending keys
    add_item(127, 16'hA001, 16'hB001, 16'hC001, 1'b0);
    add_item(64, 16'hA002, 16'hB002, 16'hC002, 1'b0);
    add_item(1, 16'hA003, 16'hB003, 16'hC003, 1'b0);
    add_item(0, 16'hA004, 16'hB004, 16'hC004, 1'b1);

    // random: one batch past capacity, one exactly full, then mostly small ones
    len = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 6);
    add_batch(len);
    add_batch(MAX_RECORDS);
    while (record_feed.size() < TOTAL_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, MAX_RECORDS + 4)
                                     : $urandom_range(1, 12);
      if (len > TOTAL_ITEMS - record_feed.size()) begin
        len = TOTAL_ITEMS - record_feed.size();
      end
      add_batch(len);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (record_feed.size() > 0 || sorted_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d records in %0d batches (%0d over capacity), %0d sorted results checked",
             records_fed, batches_done, overflow_batches, results_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
